[sv/i2crm_pkg.sv]
// ----------------------------------------------------------------------------
// i2crm_pkg
// Shared types, command codes and the byte program of the register access
// I2C master.
// ----------------------------------------------------------------------------
package i2crm_pkg;

  // Command codes carried in the action field.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_DEVICE_ADDRESS = 1'b0;
  localparam logic CFG_ACK_WAIT_LIMIT = 1'b1;

  // Register widths and reset values.
  localparam int unsigned DEV_ADDR_W = 7;
  localparam int unsigned BYTE_W     = 8;
  localparam logic [DEV_ADDR_W-1:0] DEVICE_ADDRESS_RST = '0;
  localparam logic [BYTE_W-1:0]     ACK_WAIT_LIMIT_RST = 8'd250;

  // Stream widths, padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 16;

  // One bus tick as taken from the input stream.
  typedef struct packed {
    logic              sda_sample;
    logic [BYTE_W-1:0] write_byte;
    logic [BYTE_W-1:0] reg_address;
    logic [1:0]        action;
  } item_t;

  // One result of a tick.
  typedef struct packed {
    logic              ack_missing;
    logic [BYTE_W-1:0] read_byte;
    logic              done_res;
    logic              busy_res;
    logic              sda_level;
    logic              scl_level;
  } result_t;

  // Byte-level operations of a transaction.
  typedef enum logic [2:0] {
    OP_START,
    OP_TX_ADW,
    OP_TX_REG,
    OP_TX_DAT,
    OP_TX_ADR,
    OP_RX,
    OP_STOP
  } op_t;

  // Operation sequence for a register write and for a register read.
  function automatic op_t program_op(input logic is_read, input logic [2:0] stage);
    op_t op;
    op = OP_STOP;
    case ({is_read, stage})
      4'b0_000: op = OP_START;
      4'b0_001: op = OP_TX_ADW;
      4'b0_010: op = OP_TX_REG;
      4'b0_011: op = OP_TX_DAT;
      4'b1_000: op = OP_START;
      4'b1_001: op = OP_TX_ADW;
      4'b1_010: op = OP_TX_REG;
      4'b1_011: op = OP_START;
      4'b1_100: op = OP_TX_ADR;
      4'b1_101: op = OP_RX;
      default:  op = OP_STOP;
    endcase
    return op;
  endfunction

endpackage

[sv/i2crm_fsm.sv]
// ----------------------------------------------------------------------------
// i2crm_fsm
// Bus sequencer: advances the I2C transaction by one half-phase tick per step
// and gives the line drive and status of that tick.
// ----------------------------------------------------------------------------
module i2crm_fsm (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                step,
  input  i2crm_pkg::item_t                    item,
  input  logic [i2crm_pkg::DEV_ADDR_W-1:0]    device_address,
  input  logic [i2crm_pkg::BYTE_W-1:0]        ack_wait_limit,
  output i2crm_pkg::result_t                  res
);

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_START_HI,
    PH_START_LO,
    PH_BIT_LO,
    PH_BIT_SET,
    PH_BIT_HI,
    PH_REL_LO,
    PH_REL_SDA,
    PH_ACK_WAIT,
    PH_ACK_END,
    PH_RX_LO0,
    PH_RX_REL,
    PH_RX_HI,
    PH_RX_LO,
    PH_NACK_SDA,
    PH_NACK_HI,
    PH_NACK_LO,
    PH_STOP_LO,
    PH_STOP_SCL
  } phase_t;

  phase_t                       phase, phase_next;
  logic [2:0]                   stage, stage_next;
  logic [3:0]                   bit_counter, bit_counter_next;
  logic [i2crm_pkg::BYTE_W-1:0] shift_out, shift_out_next;
  logic [i2crm_pkg::BYTE_W-1:0] shift_in, shift_in_next;
  logic [i2crm_pkg::BYTE_W-1:0] ack_wait_count, ack_wait_count_next;
  logic                         is_read, is_read_next;
  logic [i2crm_pkg::BYTE_W-1:0] held_register, held_register_next;
  logic [i2crm_pkg::BYTE_W-1:0] held_data, held_data_next;
  logic                         ack_fail, ack_fail_next;
  logic [i2crm_pkg::BYTE_W-1:0] last_read, last_read_next;
  logic                         scl_drv, scl_drv_next;
  logic                         sda_drv, sda_drv_next;
  logic                         busy, done;
  logic                         do_enter;
  logic [2:0]                   enter_stage;

  // Next state of one tick, followed by entry into a new byte operation.
  always_comb begin
    phase_next          = phase;
    stage_next          = stage;
    bit_counter_next    = bit_counter;
    shift_out_next      = shift_out;
    shift_in_next       = shift_in;
    ack_wait_count_next = ack_wait_count;
    is_read_next        = is_read;
    held_register_next  = held_register;
    held_data_next      = held_data;
    ack_fail_next       = ack_fail;
    last_read_next      = last_read;
    scl_drv_next        = scl_drv;
    sda_drv_next        = sda_drv;
    busy                = 1'b1;
    done                = 1'b0;
    do_enter            = 1'b0;
    enter_stage         = stage;

    case (phase)
      PH_IDLE: begin
        if (item.action == i2crm_pkg::ACT_WRITE || item.action == i2crm_pkg::ACT_READ) begin
          is_read_next       = (item.action == i2crm_pkg::ACT_READ);
          held_register_next = item.reg_address;
          held_data_next     = item.write_byte;
          ack_fail_next      = 1'b0;
          do_enter           = 1'b1;
          enter_stage        = 3'd0;
        end else begin
          busy         = 1'b0;
          scl_drv_next = 1'b1;
          sda_drv_next = 1'b1;
        end
      end
      PH_START_HI: begin
        phase_next   = PH_START_LO;
        scl_drv_next = 1'b1;
        sda_drv_next = 1'b0;
      end
      PH_START_LO: begin
        do_enter    = 1'b1;
        enter_stage = stage + 3'd1;
      end
      PH_BIT_LO: begin
        phase_next   = PH_BIT_SET;
        scl_drv_next = 1'b0;
        sda_drv_next = shift_out[i2crm_pkg::BYTE_W-1];
      end
      PH_BIT_SET: begin
        phase_next   = PH_BIT_HI;
        scl_drv_next = 1'b1;
      end
      PH_BIT_HI: begin
        shift_out_next   = {shift_out[i2crm_pkg::BYTE_W-2:0], 1'b0};
        bit_counter_next = bit_counter + 4'd1;
        phase_next       = (bit_counter_next >= 4'd8) ? PH_REL_LO : PH_BIT_LO;
        scl_drv_next     = 1'b0;
      end
      PH_REL_LO: begin
        phase_next   = PH_REL_SDA;
        scl_drv_next = 1'b0;
        sda_drv_next = 1'b1;
      end
      PH_REL_SDA: begin
        ack_wait_count_next = '0;
        phase_next          = PH_ACK_WAIT;
        scl_drv_next        = 1'b1;
        sda_drv_next        = 1'b1;
      end
      // Clock held high until the slave pulls SDA low or the wait runs out.
      PH_ACK_WAIT: begin
        if (!item.sda_sample) begin
          phase_next   = PH_ACK_END;
          scl_drv_next = 1'b0;
          sda_drv_next = 1'b1;
        end else if (ack_wait_count < ack_wait_limit) begin
          ack_wait_count_next = ack_wait_count + 8'd1;
          scl_drv_next        = 1'b1;
          sda_drv_next        = 1'b1;
        end else begin
          ack_fail_next = 1'b1;
          phase_next    = PH_ACK_END;
          scl_drv_next  = 1'b0;
          sda_drv_next  = 1'b1;
        end
      end
      PH_ACK_END: begin
        do_enter    = 1'b1;
        enter_stage = stage + 3'd1;
      end
      PH_RX_LO0: begin
        phase_next   = PH_RX_REL;
        scl_drv_next = 1'b0;
        sda_drv_next = 1'b1;
      end
      PH_RX_REL: begin
        phase_next   = PH_RX_HI;
        scl_drv_next = 1'b1;
        sda_drv_next = 1'b1;
      end
      PH_RX_HI: begin
        shift_in_next    = {shift_in[i2crm_pkg::BYTE_W-2:0], item.sda_sample};
        bit_counter_next = bit_counter + 4'd1;
        phase_next       = PH_RX_LO;
        scl_drv_next     = 1'b0;
        sda_drv_next     = 1'b1;
      end
      PH_RX_LO: begin
        if (bit_counter >= 4'd8) begin
          last_read_next = shift_in;
          phase_next     = PH_NACK_SDA;
          scl_drv_next   = 1'b0;
          sda_drv_next   = 1'b1;
        end else begin
          phase_next   = PH_RX_HI;
          scl_drv_next = 1'b1;
          sda_drv_next = 1'b1;
        end
      end
      // The received byte is answered with SDA released.
      PH_NACK_SDA: begin
        phase_next   = PH_NACK_HI;
        scl_drv_next = 1'b1;
        sda_drv_next = 1'b1;
      end
      PH_NACK_HI: begin
        phase_next   = PH_NACK_LO;
        scl_drv_next = 1'b0;
        sda_drv_next = 1'b1;
      end
      PH_NACK_LO: begin
        do_enter    = 1'b1;
        enter_stage = stage + 3'd1;
      end
      PH_STOP_LO: begin
        phase_next   = PH_STOP_SCL;
        scl_drv_next = 1'b1;
        sda_drv_next = 1'b0;
      end
      PH_STOP_SCL: begin
        scl_drv_next = 1'b1;
        sda_drv_next = 1'b1;
        done         = 1'b1;
        phase_next   = PH_IDLE;
      end
      default: begin
        phase_next   = PH_IDLE;
        busy         = 1'b0;
        scl_drv_next = 1'b1;
        sda_drv_next = 1'b1;
      end
    endcase

    // Entry into the next operation of the transaction program.
    if (do_enter) begin
      stage_next = enter_stage;
      case (i2crm_pkg::program_op(is_read_next, enter_stage))
        i2crm_pkg::OP_START: begin
          phase_next   = PH_START_HI;
          scl_drv_next = 1'b1;
          sda_drv_next = 1'b1;
        end
        i2crm_pkg::OP_TX_ADW: begin
          shift_out_next   = {device_address, 1'b0};
          bit_counter_next = '0;
          phase_next       = PH_BIT_LO;
          scl_drv_next     = 1'b0;
        end
        i2crm_pkg::OP_TX_REG: begin
          shift_out_next   = held_register_next;
          bit_counter_next = '0;
          phase_next       = PH_BIT_LO;
          scl_drv_next     = 1'b0;
        end
        i2crm_pkg::OP_TX_DAT: begin
          shift_out_next   = held_data_next;
          bit_counter_next = '0;
          phase_next       = PH_BIT_LO;
          scl_drv_next     = 1'b0;
        end
        i2crm_pkg::OP_TX_ADR: begin
          shift_out_next   = {device_address, 1'b1};
          bit_counter_next = '0;
          phase_next       = PH_BIT_LO;
          scl_drv_next     = 1'b0;
        end
        i2crm_pkg::OP_RX: begin
          shift_in_next    = '0;
          bit_counter_next = '0;
          phase_next       = PH_RX_LO0;
          scl_drv_next     = 1'b0;
        end
        default: begin
          phase_next   = PH_STOP_LO;
          scl_drv_next = 1'b0;
          sda_drv_next = 1'b0;
        end
      endcase
    end
  end

  // Result of the tick being stepped.
  always_comb begin
    res.scl_level   = scl_drv_next;
    res.sda_level   = sda_drv_next;
    res.busy_res    = busy;
    res.done_res    = done;
    res.read_byte   = last_read_next;
    res.ack_missing = ack_fail_next;
  end

  // Sequencer state, updated once per stepped tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      stage          <= '0;
      bit_counter    <= '0;
      shift_out      <= '0;
      shift_in       <= '0;
      ack_wait_count <= '0;
      is_read        <= 1'b0;
      held_register  <= '0;
      held_data      <= '0;
      ack_fail       <= 1'b0;
      last_read      <= '0;
      scl_drv        <= 1'b1;
      sda_drv        <= 1'b1;
    end else if (step) begin
      phase          <= phase_next;
      stage          <= stage_next;
      bit_counter    <= bit_counter_next;
      shift_out      <= shift_out_next;
      shift_in       <= shift_in_next;
      ack_wait_count <= ack_wait_count_next;
      is_read        <= is_read_next;
      held_register  <= held_register_next;
      held_data      <= held_data_next;
      ack_fail       <= ack_fail_next;
      last_read      <= last_read_next;
      scl_drv        <= scl_drv_next;
      sda_drv        <= sda_drv_next;
    end
  end

`ifndef SYNTHESIS
  // A stop completes by returning to idle with both lines released.
  assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_STOP_SCL |=> phase == PH_IDLE && scl_drv && sda_drv)
    else $error("stop did not return to idle with lines released");

  // The bit counter never runs past one byte.
  assert property (@(posedge clk) disable iff (rst) bit_counter <= 4'd8)
    else $error("bit counter beyond eight");

  // A start from idle clears the missing-acknowledge flag.
  assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_IDLE && busy |=> !ack_fail && phase == PH_START_HI)
    else $error("transaction start did not clear flag or enter start");

  // Done is reported only inside a transaction.
  assert property (@(posedge clk) disable iff (rst) done |-> busy && phase == PH_STOP_SCL)
    else $error("done outside the stop phase");
`endif

endmodule

[sv/i2c_register_access_master.sv]
// ----------------------------------------------------------------------------
// i2c_register_access_master
// Path: an accepted tick is held in the input register, takes one step of the
// bus sequencer, and its result is held in the output register for the stream.
// Throughput: one tick per cycle while the result stream is not stalled.
// Reset: synchronous rst returns the sequencer to idle with both lines
// released, empties both stream registers and restores register defaults.
// ----------------------------------------------------------------------------
module i2c_register_access_master (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write port.
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [i2crm_pkg::BYTE_W-1:0]         cfg_data,
  // Tick stream in.
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // action[1:0], reg_address[9:2], write_byte[17:10], sda_sample[18], zero fill
  input  logic [i2crm_pkg::IN_TDATA_W-1:0]     s_tdata,
  // Result stream out.
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // scl_level[0], sda_level[1], busy_res[2], read_byte[10:3], ack_missing[11],
  // zero fill
  output logic [i2crm_pkg::OUT_TDATA_W-1:0]    m_tdata,
  // done_res: final tick of a transaction
  output logic                                 m_tlast
);

  logic                               in_valid;
  i2crm_pkg::item_t                   in_item;
  logic                               advance;
  logic [i2crm_pkg::DEV_ADDR_W-1:0]   device_address;
  logic [i2crm_pkg::BYTE_W-1:0]       ack_wait_limit;
  i2crm_pkg::result_t                 step_res;
  logic                               out_valid;
  i2crm_pkg::result_t                 out_res;

  // The held tick steps whenever the output register is free or draining.
  assign advance  = in_valid && (!out_valid || m_tready);
  assign s_tready = !in_valid || advance;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      device_address <= i2crm_pkg::DEVICE_ADDRESS_RST;
      ack_wait_limit <= i2crm_pkg::ACK_WAIT_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        i2crm_pkg::CFG_DEVICE_ADDRESS: device_address <= cfg_data[i2crm_pkg::DEV_ADDR_W-1:0];
        i2crm_pkg::CFG_ACK_WAIT_LIMIT: ack_wait_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.action      <= s_tdata[1:0];
      in_item.reg_address <= s_tdata[9:2];
      in_item.write_byte  <= s_tdata[17:10];
      in_item.sda_sample  <= s_tdata[18];
    end
  end

  // Bus sequencer.
  i2crm_fsm u_fsm (
    .clk            (clk),
    .rst            (rst),
    .step           (advance),
    .item           (in_item),
    .device_address (device_address),
    .ack_wait_limit (ack_wait_limit),
    .res            (step_res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_res.done_res;
  assign m_tdata  = {4'b0000, out_res.ack_missing, out_res.read_byte,
                     out_res.busy_res, out_res.sda_level, out_res.scl_level};

endmodule
